[design/ccic_pkg.sv]
// ccic_pkg: shared types, command codes and helpers for the coin credit input controller
// depends on nothing; imported by coin_credit_input_controller
package ccic_pkg;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_CREDIT  = 2'd1,
    MODE_SWITCH  = 2'd2
  } mode_t;

  typedef logic [1:0] phase_t;
  typedef logic [6:0] credit_t;

  localparam logic [7:0] CMD_COINAGE    = 8'd1;
  localparam logic [7:0] CMD_CREDIT     = 8'd2;
  localparam logic [7:0] CMD_REMAP_OFF  = 8'd3;
  localparam logic [7:0] CMD_REMAP_ON   = 8'd4;
  localparam logic [7:0] CMD_SWITCH     = 8'd5;

  localparam phase_t PHASE_STATUS = 2'd0;
  localparam phase_t PHASE_JOY1   = 2'd1;
  localparam phase_t PHASE_JOY2   = 2'd2;

  localparam credit_t CREDIT_MAX = 7'd99;

  localparam logic OP_WRITE = 1'b0;

  // two bcd digits of a count at most 99
  function automatic logic [7:0] to_bcd(input credit_t count);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (count >= 7'(10 * i)) tens = 4'(i);
    end
    ones = count - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

[design/coin_credit_input_controller.sv]
// coin_credit_input_controller: host bus facing coin, credit and joystick input controller
// depends on ccic_pkg
//
// Each request is one host bus access: a write either swallows one pending coinage
// byte or decodes a command (coinage, credit mode, remap off/on, switch mode); a read
// is answered by a three-phase cycle that returns packed switch nibbles in switch mode,
// or the bcd credit count and two joystick bytes with fire edge/held bits in credit
// mode. Every request yields exactly one response (read_data, fault); writes answer 0.
// One request is taken per clock unless in_stall holds it: all state updates and the
// response are computed combinationally from the request fields and the control
// registers, and the response lands in an output register. A request is taken while
// that register is empty or being drained, so throughput is one request per cycle
// outside stalls; in_stall only rises when a response is held by out_stall.
module coin_credit_input_controller #(
  parameter int COINAGE_LEN = 4
) (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] write_data,
  input  logic [3:0] port_buttons,
  input  logic [3:0] port_coins,
  input  logic [3:0] port_joy_one,
  input  logic [3:0] port_joy_two,
  // response channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       fault
);
  import ccic_pkg::*;

  localparam int PendW = $clog2(COINAGE_LEN + 1);

  // control state
  mode_t            mode_sel, mode_sel_next;
  logic             remap_on, remap_on_next;
  credit_t          credit_count, credit_count_next;
  logic [PendW-1:0] pending_bytes, pending_bytes_next;
  phase_t           read_phase, read_phase_next;
  logic [3:0]       prev_coin_bits, prev_coin_bits_next;
  logic [1:0]       prev_fire_bits, prev_fire_bits_next;

  // response computed this cycle
  logic [7:0] data_next;
  logic       fault_next;

  logic accept;

  // response register drains or is empty: take a new request
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // credit path intermediates
  logic [3:0] coin_now;
  logic [3:0] coin_rise;
  credit_t    cred_a, cred_b, cred_c, cred_d;
  phase_t     phase_adv;

  // joystick path for the player selected by the phase
  logic       player;
  logic       fire_held;
  logic       fire_edge;
  logic [3:0] joy_sel;

  always_comb begin
    // pressed = 1: bit0 start one, bit1 start two, bit2 coin a, bit3 coin b
    coin_now  = {~port_coins[1:0], ~port_buttons[3:2]};
    coin_rise = coin_now & ~prev_coin_bits;

    // coins first (saturating), then start two, then start one
    cred_a = (coin_rise[3] && credit_count < CREDIT_MAX) ? credit_count + 7'd1 : credit_count;
    cred_b = (coin_rise[2] && cred_a < CREDIT_MAX) ? cred_a + 7'd1 : cred_a;
    cred_c = (coin_rise[1] && cred_b > 7'd2) ? cred_b - 7'd2 : cred_b;
    cred_d = (coin_rise[0] && cred_c > 7'd1) ? cred_c - 7'd1 : cred_c;

    phase_adv = (read_phase >= PHASE_JOY2) ? PHASE_STATUS : read_phase + 2'd1;

    player    = (read_phase == PHASE_JOY2);
    fire_held = ~port_buttons[{1'b0, player}];
    fire_edge = fire_held & ~prev_fire_bits[player];
    joy_sel   = player ? port_joy_two : port_joy_one;
  end

  // next state
  always_comb begin
    mode_sel_next       = mode_sel;
    remap_on_next       = remap_on;
    credit_count_next   = credit_count;
    pending_bytes_next  = pending_bytes;
    read_phase_next     = read_phase;
    prev_coin_bits_next = prev_coin_bits;
    prev_fire_bits_next = prev_fire_bits;

    if (op == OP_WRITE) begin
      if (pending_bytes != '0) begin
        // coinage bytes are consumed and ignored
        pending_bytes_next = pending_bytes - PendW'(1);
      end else begin
        case (write_data)
          CMD_COINAGE: pending_bytes_next = PendW'(COINAGE_LEN);
          CMD_CREDIT: begin
            mode_sel_next   = MODE_CREDIT;
            read_phase_next = PHASE_STATUS;
          end
          CMD_REMAP_OFF: remap_on_next = 1'b0;
          CMD_REMAP_ON:  remap_on_next = 1'b1;
          CMD_SWITCH: begin
            mode_sel_next   = MODE_SWITCH;
            read_phase_next = PHASE_STATUS;
          end
          default: ;
        endcase
      end
    end else begin
      case (mode_sel)
        MODE_SWITCH: read_phase_next = phase_adv;
        MODE_CREDIT: begin
          read_phase_next = phase_adv;
          if (read_phase == PHASE_STATUS) begin
            credit_count_next   = cred_d;
            prev_coin_bits_next = coin_now;
          end else if (!remap_on) begin
            prev_fire_bits_next[player] = fire_held;
          end
        end
        default: ;  // unknown mode keeps the phase
      endcase
    end
  end

  // response
  always_comb begin
    data_next  = 8'd0;
    fault_next = 1'b0;
    if (op != OP_WRITE) begin
      case (mode_sel)
        MODE_SWITCH: begin
          if (read_phase == PHASE_STATUS)
            data_next = {port_coins, port_buttons};
          else if (read_phase == PHASE_JOY1)
            data_next = {port_joy_two, port_joy_one};
        end
        MODE_CREDIT: begin
          if (read_phase == PHASE_STATUS)
            data_next = to_bcd(cred_d);
          else if (remap_on)
            fault_next = 1'b1;  // joystick phase read with remap on
          else
            data_next = {2'b00, ~fire_held, ~fire_edge, joy_sel};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel       <= MODE_UNKNOWN;
      remap_on       <= 1'b0;
      credit_count   <= '0;
      pending_bytes  <= '0;
      read_phase     <= PHASE_STATUS;
      prev_coin_bits <= '0;
      prev_fire_bits <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        mode_sel       <= mode_sel_next;
        remap_on       <= remap_on_next;
        credit_count   <= credit_count_next;
        pending_bytes  <= pending_bytes_next;
        read_phase     <= read_phase_next;
        prev_coin_bits <= prev_coin_bits_next;
        prev_fire_bits <= prev_fire_bits_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= data_next;
      fault     <= fault_next;
    end
  end

endmodule

[dv/coin_credit_input_controller_tb.sv]
// testbench for coin_credit_input_controller: directed and random host bus requests,
// responses checked against an in-bench model of the command, switch and credit logic
// depends on ccic_pkg and the coin_credit_input_controller rtl
`timescale 1ns / 100ps

module testbench;
  import ccic_pkg::*;

  localparam int COINAGE_LEN = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int HOLD_BACK_AT = 950;
  localparam logic OP_READ = ~OP_WRITE;
  // command bytes the block does not decode
  localparam logic [7:0] CMD_NONE = 8'd0;
  localparam logic [7:0] CMD_PAST_LAST = 8'd6;
  localparam logic [7:0] CMD_ALL_ONES = 8'hFF;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       op = OP_WRITE;
  logic [7:0] write_data = 8'd0;
  logic [3:0] port_buttons = 4'd0;
  logic [3:0] port_coins = 4'd0;
  logic [3:0] port_joy_one = 4'd0;
  logic [3:0] port_joy_two = 4'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] read_data;
  logic       fault;

  int  cycles = 0;
  int  sent = 0;
  bit  quiet = 1'b0;
  bit  held_back = 1'b0;

  // tracks controller state and the byte each request should answer with
  class input_scoreboard;
    mode_t      mode;
    logic       remap;
    credit_t    credits;
    logic [2:0] pending;
    phase_t     phase;
    logic [3:0] prev_coin;
    logic [1:0] prev_fire;
    logic [8:0] due_responses[$];  // {fault, read_data}
    int         errors;
    int         checked;
    int         faults;
    int         peak;
    int         lost_coins;

    function new();
      mode = MODE_UNKNOWN;
      remap = 1'b0;
      credits = '0;
      pending = '0;
      phase = PHASE_STATUS;
      prev_coin = '0;
      prev_fire = '0;
      errors = 0;
      checked = 0;
      faults = 0;
      peak = 0;
      lost_coins = 0;
    endfunction

    // joystick byte: fire edge active low in bit 4, raw fire level in bit 5
    function logic [7:0] joy_byte(logic [3:0] joy, logic [3:0] btn, int player);
      logic held;
      logic fire_new;
      held = ~btn[player];
      fire_new = held & ~prev_fire[player];
      prev_fire[player] = held;
      return {2'b00, ~held, ~fire_new, joy};
    endfunction

    function void apply_request(logic rd, logic [7:0] wd, logic [3:0] btn,
                                logic [3:0] coins, logic [3:0] j1, logic [3:0] j2);
      logic [7:0] data;
      logic       flt;
      phase_t     p;
      logic [3:0] now;
      data = 8'd0;
      flt = 1'b0;
      if (rd == OP_WRITE) begin
        if (pending != 3'd0) begin
          pending = pending - 3'd1;
        end else begin
          case (wd)
            CMD_COINAGE: pending = 3'(COINAGE_LEN);
            CMD_CREDIT: begin
              mode = MODE_CREDIT;
              phase = PHASE_STATUS;
            end
            CMD_REMAP_OFF: remap = 1'b0;
            CMD_REMAP_ON: remap = 1'b1;
            CMD_SWITCH: begin
              mode = MODE_SWITCH;
              phase = PHASE_STATUS;
            end
            default: ;
          endcase
        end
      end else if (mode == MODE_SWITCH || mode == MODE_CREDIT) begin
        p = phase;
        phase = (phase >= PHASE_JOY2) ? PHASE_STATUS : phase + 2'd1;
        if (mode == MODE_SWITCH) begin
          if (p == PHASE_STATUS) data = {coins, btn};
          else if (p == PHASE_JOY1) data = {j2, j1};
        end else if (p == PHASE_STATUS) begin
          // pressed = 1: start one, start two, coin a, coin b
          now = {~coins[1:0], ~btn[3:2]};
          for (int b = 3; b >= 2; b--) begin
            if (now[b] && !prev_coin[b]) begin
              if (credits < CREDIT_MAX) credits = credits + 7'd1;
              else lost_coins++;
            end
          end
          if (now[1] && !prev_coin[1] && credits > 7'd2) credits = credits - 7'd2;
          if (now[0] && !prev_coin[0] && credits > 7'd1) credits = credits - 7'd1;
          prev_coin = now;
          if (credits > peak) peak = credits;
          data = {4'(credits / 7'd10), 4'(credits % 7'd10)};
        end else if (remap) begin
          flt = 1'b1;
        end else if (p == PHASE_JOY1) begin
          data = joy_byte(j1, btn, 0);
        end else begin
          data = joy_byte(j2, btn, 1);
        end
      end
      due_responses.push_back({flt, data});
    endfunction

    function void check_response(logic [7:0] data, logic flt);
      logic [8:0] want;
      if (due_responses.size() == 0) begin
        $error("response with nothing outstanding: read_data=%02h fault=%0b", data, flt);
        errors++;
        return;
      end
      want = due_responses.pop_front();
      checked++;
      if (want[8]) faults++;
      if (data !== want[7:0]) begin
        $error("read_data mismatch: expected %02h, got %02h", want[7:0], data);
        errors++;
      end
      if (flt !== want[8]) begin
        $error("fault mismatch: expected %0b, got %0b", want[8], flt);
        errors++;
      end
    endfunction
  endclass

  input_scoreboard sb;

  coin_credit_input_controller #(
    .COINAGE_LEN(COINAGE_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .write_data(write_data),
    .port_buttons(port_buttons),
    .port_coins(port_coins),
    .port_joy_one(port_joy_one),
    .port_joy_two(port_joy_two),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .fault(fault)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** coin_credit_input_controller: FAILED **");
      $finish;
    end
  end

  // a response moves when valid is up and we are not stalling
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_response(read_data, fault);
  end

  // response side: random stall before taking each response
  initial begin
    int hold;
    wait (!rst);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 4);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request: random gap, then hold it until the block takes it
  task automatic send_request(input logic rd, input logic [7:0] wd, input logic [3:0] btn,
                              input logic [3:0] coins, input logic [3:0] j1,
                              input logic [3:0] j2);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    op <= rd;
    write_data <= wd;
    port_buttons <= btn;
    port_coins <= coins;
    port_joy_one <= j1;
    port_joy_two <= j2;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.apply_request(rd, wd, btn, coins, j1, j2);
    sent++;
  endtask

  task automatic write_cmd(input logic [7:0] wd);
    send_request(OP_WRITE, wd, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
  endtask

  // start buttons stay released unless spending is allowed
  task automatic read_random(input bit spend);
    send_request(OP_READ, 8'($urandom), {spend ? 2'($urandom) : 2'b11, 2'($urandom)},
                 4'($urandom), 4'($urandom), 4'($urandom));
  endtask

  task automatic drain_coinage();
    while (sb.pending != 3'd0) write_cmd(8'($urandom));
  endtask

  // credit mode, then read triples with coins pressed on every other status read
  task automatic feed_credits(input int triples);
    drain_coinage();
    write_cmd(CMD_CREDIT);
    for (int i = 0; i < triples; i++) begin
      send_request(OP_READ, 8'($urandom), {2'b11, 2'($urandom)},
                   {2'($urandom), i[0] ? 2'b11 : 2'b00}, 4'($urandom), 4'($urandom));
      read_random(1'b0);
      read_random(1'b0);
    end
  endtask

  initial begin
    int kind;
    int n;
    bit spend;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no mode selected yet: reads answer zero
    send_request(OP_READ, 8'h00, 4'h0, 4'h0, 4'h0, 4'h0);
    send_request(OP_READ, 8'hFF, 4'hF, 4'hF, 4'hF, 4'hF);
    // undecoded commands are ignored
    send_request(OP_WRITE, CMD_NONE, 4'hF, 4'hF, 4'hF, 4'hF);
    write_cmd(CMD_PAST_LAST);
    write_cmd(CMD_ALL_ONES);
    // switch mode, all three phases
    write_cmd(CMD_SWITCH);
    send_request(OP_READ, 8'h00, 4'hF, 4'hF, 4'h0, 4'h0);
    send_request(OP_READ, 8'h00, 4'h0, 4'h0, 4'hF, 4'h0);
    send_request(OP_READ, 8'hFF, 4'hF, 4'hF, 4'hF, 4'hF);
    send_request(OP_READ, 8'h00, 4'h0, 4'h0, 4'h0, 4'hF);
    // coinage swallows the next bytes even when they look like commands
    write_cmd(CMD_COINAGE);
    write_cmd(CMD_CREDIT);
    write_cmd(CMD_REMAP_ON);
    write_cmd(CMD_SWITCH);
    write_cmd(CMD_COINAGE);
    // credit mode: both coins, then fire presses on both joysticks
    write_cmd(CMD_CREDIT);
    send_request(OP_READ, 8'h00, 4'hF, 4'h0, 4'h0, 4'h0);
    send_request(OP_READ, 8'h00, 4'hE, 4'hF, 4'hA, 4'h0);
    send_request(OP_READ, 8'h00, 4'hD, 4'hF, 4'h0, 4'h5);
    // start two with only two credits spends nothing
    send_request(OP_READ, 8'h00, 4'h7, 4'hF, 4'h0, 4'h0);
    // joystick phases fault while remap is on
    write_cmd(CMD_REMAP_ON);
    send_request(OP_READ, 8'h00, 4'h0, 4'h0, 4'hF, 4'hF);
    send_request(OP_READ, 8'h00, 4'h0, 4'h0, 4'hF, 4'hF);
    send_request(OP_READ, 8'h00, 4'hF, 4'hF, 4'h0, 4'h0);
    write_cmd(CMD_REMAP_OFF);

    // long coin run so the count reaches saturation
    feed_credits(105);

    while (sent < RANDOM_REQUESTS) begin
      // once mid run, let every response come back before going on
      if (!held_back && sent >= HOLD_BACK_AT) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_responses.size() != 0) @(posedge clk);
        held_back = 1'b1;
      end
      quiet = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        drain_coinage();
        write_cmd($urandom_range(0, 1) ? CMD_CREDIT : CMD_SWITCH);
        n = $urandom_range(3, 30);
        spend = ($urandom_range(0, 2) == 0);
        repeat (n) read_random(spend);
      end else if (kind < 45) begin
        feed_credits($urandom_range(3, 20));
      end else if (kind < 55) begin
        write_cmd($urandom_range(0, 2) ? CMD_REMAP_OFF : CMD_REMAP_ON);
      end else if (kind < 65) begin
        // coinage with a random, sometimes short, byte count
        write_cmd(CMD_COINAGE);
        n = $urandom_range(0, COINAGE_LEN + 1);
        repeat (n) write_cmd(8'($urandom));
      end else if (kind < 80) begin
        n = $urandom_range(1, 4);
        repeat (n) write_cmd(8'($urandom));
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) read_random($urandom_range(0, 1));
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.due_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d checked responses, %0d of them remap faults",
             sent, sb.checked, sb.faults);
    $display("credit count peaked at %0d with %0d coins lost at the cap", sb.peak,
             sb.lost_coins);
    if (sb.errors == 0) begin
      $display("** coin_credit_input_controller: PASSED **");
    end else begin
      $display("** coin_credit_input_controller: FAILED **");
    end
    $finish;
  end

endmodule
